>>> hw/rtl/pat_pkg.sv
package pat_pkg;

  // Fixed formats of the point and configuration fields
  localparam int COORD_BITS         = 32;
  localparam int FRAC_Q             = 16;
  localparam int COEF_W             = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int NUM_AXES           = 3;

  // b*w and d*w: full product, then the upper bits after the Q16 shift
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SHV_W  = PROD_W - FRAC_Q;
  // p - b*w and p + d*w need one more bit
  localparam int DIFF_W = SHV_W + 1;

  // Register file
  localparam int NUM_REGS   = 8;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_LSB   = 3;
  localparam int ADDR_W     = $clog2(NUM_REGS) + ADDR_LSB;

  // Reset values: identity matrix at 14 fraction bits
  localparam logic [COORD_BITS-1:0]      PIVOT_RST = '0;
  localparam logic [COEF_W*NUM_AXES-1:0] ROW_A_RST = 48'h0000_0000_4000;
  localparam logic [COEF_W*NUM_AXES-1:0] ROW_B_RST = 48'h0000_4000_0000;
  localparam logic [COEF_W*NUM_AXES-1:0] ROW_C_RST = 48'h4000_0000_0000;

  // Cycles from an accepted command to its done strobe
  localparam int LATENCY = 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SHV_W-1:0]      shv_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  typedef enum logic [1:0] {
    OP_SCALE_UP   = 2'd0,
    OP_SCALE_DOWN = 2'd1,
    OP_TRANSLATE  = 2'd2,
    OP_ROTATE     = 2'd3
  } opcode_t;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_PIVOT_X  = 3'd0,
    REG_PIVOT_Y  = 3'd1,
    REG_PIVOT_Z  = 3'd2,
    REG_ROW_A    = 3'd3,
    REG_ROW_B    = 3'd4,
    REG_ROW_C    = 3'd5,
    REG_SHIFT_XY = 3'd6,
    REG_SHIFT_Z  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    opcode_t opcode;
    coord_t  coord_x;
    coord_t  coord_y;
    coord_t  coord_z;
    coord_t  weight;
  } in_beat_t;

  typedef struct packed {
    coord_t new_x;
    coord_t new_y;
    coord_t new_z;
    coord_t new_weight;
    logic   clipped;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]      pivot_x;
    logic [COORD_BITS-1:0]      pivot_y;
    logic [COORD_BITS-1:0]      pivot_z;
    logic [COEF_W*NUM_AXES-1:0] row_a;
    logic [COEF_W*NUM_AXES-1:0] row_b;
    logic [COEF_W*NUM_AXES-1:0] row_c;
    logic [2*COORD_BITS-1:0]    shift_xy;
    logic [COORD_BITS-1:0]      shift_z;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    opcode_t op;
  } pat_ctl_t;

  // After the weight products
  typedef struct packed {
    coord_t                    weight;
    coord_t [NUM_AXES-1:0]     p;
    shv_t   [NUM_AXES-1:0]     m;
  } off_s1_t;

  // After the offset stage: d feeds the multipliers, base is added at the end
  typedef struct packed {
    coord_t                weight;
    diff_t [NUM_AXES-1:0]  d;
    diff_t [NUM_AXES-1:0]  base;
  } off_s2_t;

  // Multiplier coefficient width: Q1.14 matrix entries or the 1.25 scale factor
  function automatic int coef_mul_w(input int frac);
    coef_mul_w = (frac + 2 > COEF_W) ? frac + 2 : COEF_W;
  endfunction

  // Width of a three-term dot product
  function automatic int dot_sum_w(input int frac);
    dot_sum_w = DIFF_W + coef_mul_w(frac) + 2;
  endfunction

  function automatic diff_t sext_coord(input coord_t v);
    sext_coord = {{(DIFF_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic diff_t sext_shv(input shv_t v);
    sext_shv = {{(DIFF_W-SHV_W){v[SHV_W-1]}}, v};
  endfunction

endpackage

>>> hw/rtl/pat_cfg_regs.sv
module pat_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pat_pkg::ADDR_W-1:0]       paddr,
  input  logic [pat_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pat_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pat_pkg::cfg_t                    cfg
);
  import pat_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes, one 64-bit slot per register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pivot_x  <= PIVOT_RST;
      cfg.pivot_y  <= PIVOT_RST;
      cfg.pivot_z  <= PIVOT_RST;
      cfg.row_a    <= ROW_A_RST;
      cfg.row_b    <= ROW_B_RST;
      cfg.row_c    <= ROW_C_RST;
      cfg.shift_xy <= '0;
      cfg.shift_z  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PIVOT_X:  cfg.pivot_x  <= pwdata[COORD_BITS-1:0];
        REG_PIVOT_Y:  cfg.pivot_y  <= pwdata[COORD_BITS-1:0];
        REG_PIVOT_Z:  cfg.pivot_z  <= pwdata[COORD_BITS-1:0];
        REG_ROW_A:    cfg.row_a    <= pwdata[COEF_W*NUM_AXES-1:0];
        REG_ROW_B:    cfg.row_b    <= pwdata[COEF_W*NUM_AXES-1:0];
        REG_ROW_C:    cfg.row_c    <= pwdata[COEF_W*NUM_AXES-1:0];
        REG_SHIFT_XY: cfg.shift_xy <= pwdata[2*COORD_BITS-1:0];
        REG_SHIFT_Z:  cfg.shift_z  <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended
  always_comb begin
    case (idx)
      REG_PIVOT_X:  prdata = CFG_DATA_W'(cfg.pivot_x);
      REG_PIVOT_Y:  prdata = CFG_DATA_W'(cfg.pivot_y);
      REG_PIVOT_Z:  prdata = CFG_DATA_W'(cfg.pivot_z);
      REG_ROW_A:    prdata = CFG_DATA_W'(cfg.row_a);
      REG_ROW_B:    prdata = CFG_DATA_W'(cfg.row_b);
      REG_ROW_C:    prdata = CFG_DATA_W'(cfg.row_c);
      REG_SHIFT_XY: prdata = CFG_DATA_W'(cfg.shift_xy);
      REG_SHIFT_Z:  prdata = CFG_DATA_W'(cfg.shift_z);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pat_offset.sv
module pat_offset (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  pat_pkg::in_beat_t  cmd,
  input  pat_pkg::cfg_t      cfg,
  output pat_pkg::pat_ctl_t  ctl,
  output pat_pkg::off_s2_t   data
);
  import pat_pkg::*;

  logic                   valid1;
  opcode_t                op1;
  logic                   valid2;
  opcode_t                op2;
  off_s1_t                s1;
  off_s1_t                s1_next;
  off_s2_t                s2_next;
  coord_t [NUM_AXES-1:0]  pin;
  coord_t [NUM_AXES-1:0]  factor;
  logic signed [PROD_W-1:0] prod;

  // Stage 1: pivot*w, or shift*w for translate, truncated by the Q16 shift
  always_comb begin
    pin[0] = cmd.coord_x;
    pin[1] = cmd.coord_y;
    pin[2] = cmd.coord_z;
    if (cmd.opcode == OP_TRANSLATE) begin
      factor[0] = cfg.shift_xy[COORD_BITS-1:0];
      factor[1] = cfg.shift_xy[2*COORD_BITS-1:COORD_BITS];
      factor[2] = cfg.shift_z;
    end else begin
      factor[0] = cfg.pivot_x;
      factor[1] = cfg.pivot_y;
      factor[2] = cfg.pivot_z;
    end
    s1_next.weight = cmd.weight;
    s1_next.p      = pin;
    prod           = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      prod = PROD_W'($signed(factor[i])) * PROD_W'($signed(cmd.weight));
      s1_next.m[i] = prod[PROD_W-1:FRAC_Q];
    end
  end

  // Stage 2: offset from the pivot; base is what gets added back at the end
  always_comb begin
    s2_next.weight = s1.weight;
    for (int i = 0; i < NUM_AXES; i++) begin
      s2_next.d[i] = sext_coord(s1.p[i]) - sext_shv(s1.m[i]);
      if (op1 == OP_TRANSLATE) begin
        s2_next.base[i] = sext_coord(s1.p[i]) + sext_shv(s1.m[i]);
      end else begin
        s2_next.base[i] = sext_shv(s1.m[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= cmd.opcode;
    s1   <= s1_next;
    op2  <= op1;
    data <= s2_next;
  end

  assign ctl.valid = valid2;
  assign ctl.op    = op2;

endmodule

>>> hw/rtl/pat_dot.sv
module pat_dot #(
  parameter int COEF_FRAC_BITS = pat_pkg::COEF_FRAC_BITS_DEF,
  localparam int SumW = pat_pkg::dot_sum_w(COEF_FRAC_BITS)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  pat_pkg::pat_ctl_t                          ctl,
  input  pat_pkg::off_s2_t                           data,
  input  pat_pkg::cfg_t                              cfg,
  output logic                                       valid,
  output pat_pkg::coord_t                            weight,
  output pat_pkg::diff_t [pat_pkg::NUM_AXES-1:0]     base,
  output logic [pat_pkg::NUM_AXES-1:0][SumW-1:0]     sum
);
  import pat_pkg::*;

  localparam int CoefW     = coef_mul_w(COEF_FRAC_BITS);
  localparam int ProdW     = DIFF_W + CoefW;
  localparam int ScaleUp   = (1 << COEF_FRAC_BITS) + (1 << (COEF_FRAC_BITS - 2));
  localparam int ScaleDown = (((16 << COEF_FRAC_BITS) / 10) + 1) / 2;

  logic [NUM_AXES-1:0][COEF_W*NUM_AXES-1:0] rows;
  logic signed [CoefW-1:0]  coef      [NUM_AXES][NUM_AXES];
  logic signed [ProdW-1:0]  d_ext     [NUM_AXES];
  logic signed [ProdW-1:0]  prod_next [NUM_AXES][NUM_AXES];
  logic signed [ProdW-1:0]  prod      [NUM_AXES][NUM_AXES];
  logic                     valid3;
  coord_t                   weight3;
  diff_t [NUM_AXES-1:0]     base3;
  logic [NUM_AXES-1:0][SumW-1:0] sum_next;

  assign rows[0] = cfg.row_a;
  assign rows[1] = cfg.row_b;
  assign rows[2] = cfg.row_c;

  // Coefficients: rotation matrix, scale on the diagonal, zero for translate
  always_comb begin
    for (int v = 0; v < NUM_AXES; v++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        case (ctl.op)
          OP_SCALE_UP:   coef[v][k] = (v == k) ? CoefW'(ScaleUp) : '0;
          OP_SCALE_DOWN: coef[v][k] = (v == k) ? CoefW'(ScaleDown) : '0;
          OP_ROTATE:     coef[v][k] = CoefW'($signed(rows[v][COEF_W*k +: COEF_W]));
          default:       coef[v][k] = '0;
        endcase
      end
    end
  end

  // Stage 3: nine exact products d[k]*c[v][k]
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      d_ext[k] = ProdW'($signed(data.d[k]));
    end
    for (int v = 0; v < NUM_AXES; v++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        prod_next[v][k] = d_ext[k] * ProdW'(coef[v][k]);
      end
    end
  end

  // Stage 4: exact row sums
  always_comb begin
    logic signed [SumW-1:0] acc;
    acc = '0;
    for (int v = 0; v < NUM_AXES; v++) begin
      acc = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        acc = acc + SumW'(prod[v][k]);
      end
      sum_next[v] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid3 <= ctl.valid;
      valid  <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_next;
    weight3 <= data.weight;
    base3   <= data.base;
    sum     <= sum_next;
    weight  <= weight3;
    base    <= base3;
  end

endmodule

>>> hw/rtl/pat_sat.sv
module pat_sat #(
  parameter int COEF_FRAC_BITS = pat_pkg::COEF_FRAC_BITS_DEF,
  localparam int SumW = pat_pkg::dot_sum_w(COEF_FRAC_BITS)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       valid,
  input  pat_pkg::coord_t                            weight,
  input  pat_pkg::diff_t [pat_pkg::NUM_AXES-1:0]     base,
  input  logic [pat_pkg::NUM_AXES-1:0][SumW-1:0]     sum,
  output logic                                       done,
  output pat_pkg::out_beat_t                         result
);
  import pat_pkg::*;

  localparam int ResW = SumW + 1;
  localparam int HiW  = ResW - COORD_BITS + 1;
  localparam logic [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CoordMin = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [ResW-1:0]      res [NUM_AXES];
  logic [HiW-1:0]              hi;
  coord_t [NUM_AXES-1:0]       sat;
  logic                        clip_next;
  out_beat_t                   result_next;

  // Stage 5: drop the coefficient fraction, add back base, clamp
  always_comb begin
    clip_next = 1'b0;
    hi        = '0;
    for (int v = 0; v < NUM_AXES; v++) begin
      res[v] = ResW'($signed(sum[v]) >>> COEF_FRAC_BITS) + ResW'($signed(base[v]));
      hi     = res[v][ResW-1:COORD_BITS-1];
      if ((&hi) || !(|hi)) begin
        sat[v] = res[v][COORD_BITS-1:0];
      end else begin
        clip_next = 1'b1;
        sat[v]    = res[v][ResW-1] ? CoordMin : CoordMax;
      end
    end
    result_next.new_x      = sat[0];
    result_next.new_y      = sat[1];
    result_next.new_z      = sat[2];
    result_next.new_weight = weight;
    result_next.clipped    = clip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // A clipped beat carries at least one rail value
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (done && result.clipped) |->
      (result.new_x == CoordMax || result.new_x == CoordMin ||
       result.new_y == CoordMax || result.new_y == CoordMin ||
       result.new_z == CoordMax || result.new_z == CoordMin))
    else $error("clipped set without a saturated coordinate");

endmodule

>>> hw/rtl/pivot_affine_point_transform.sv
// Channel  | Handshake             | Payload          | Notes
// command  | start / busy          | cmd (in_beat_t)  | taken when start && !busy
// result   | done                  | result           | one-cycle strobe, no backpressure
// config   | psel/penable/pwrite   | paddr, pwdata    | 64-bit slots, pready tied high
//
// One command can be taken every cycle. The stages are: weight products (32x32),
// offset from the pivot, 3x3 coefficient products, row sums, shift/add/clamp.
// busy is high only during reset; rst is synchronous and clears the valid bits
// of every stage and restores the register defaults (identity matrix).
// Results cannot be held off, so the pipeline never stalls.
module pivot_affine_point_transform #(
  parameter int COEF_FRAC_BITS = pat_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  pat_pkg::in_beat_t                cmd,
  output logic                             done,
  output pat_pkg::out_beat_t               result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pat_pkg::ADDR_W-1:0]       paddr,
  input  logic [pat_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pat_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pat_pkg::*;

  localparam int SumW = dot_sum_w(COEF_FRAC_BITS);

  logic                          accept;
  cfg_t                          cfg;
  pat_ctl_t                      off_ctl;
  off_s2_t                       off_data;
  logic                          dot_valid;
  coord_t                        dot_weight;
  diff_t [NUM_AXES-1:0]          dot_base;
  logic [NUM_AXES-1:0][SumW-1:0] dot_sum;

  assign busy   = rst;
  assign accept = start && !busy;

  pat_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pat_offset u_offset (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .cfg    (cfg),
    .ctl    (off_ctl),
    .data   (off_data)
  );

  pat_dot #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dot (
    .clk    (clk),
    .rst    (rst),
    .ctl    (off_ctl),
    .data   (off_data),
    .cfg    (cfg),
    .valid  (dot_valid),
    .weight (dot_weight),
    .base   (dot_base),
    .sum    (dot_sum)
  );

  pat_sat #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sat (
    .clk    (clk),
    .rst    (rst),
    .valid  (dot_valid),
    .weight (dot_weight),
    .base   (dot_base),
    .sum    (dot_sum),
    .done   (done),
    .result (result)
  );

  // Every accepted command comes out as a done strobe
  a_cmd_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted command produced no result");

  // No result beat without a command behind it
  a_done_from_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result beat without a matching command");

  // Weight rides through the pipeline untouched
  a_weight_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.new_weight == $past(cmd.weight, LATENCY)))
    else $error("weight altered in the pipeline");

endmodule
